// ===== design/maml_pkg.sv =====
// Shared types and constants for the multi-alarm match and latch unit.
`timescale 1ns / 1ps
`default_nettype none

package maml_pkg;

  // Field widths of the item ports
  localparam int FUNC_W  = 2;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int AIDX_W  = 3;
  localparam int MEL_W   = 4;

  // Bank size: default and largest the index fields can address
  localparam int NUM_ALARMS_DEF = 8;
  localparam int MAX_ALARMS     = 8;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SILENCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONFIG  = 2'd2;

  // One alarm entry as held in the table (16 bits)
  typedef struct packed {
    logic [MEL_W-1:0]  melody;
    logic              enable;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
  } maml_entry_t;

  // Write request into the alarm table
  typedef struct packed {
    logic              en;
    logic [AIDX_W-1:0] addr;
    maml_entry_t       data;
  } maml_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } maml_state_t;

endpackage

`default_nettype wire

// ===== design/maml_table.sv =====
// Alarm entry memory: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module maml_table #(
  parameter int  NUM_ALARMS = maml_pkg::NUM_ALARMS_DEF,
  localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire maml_pkg::maml_wr_t   wr,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output maml_pkg::maml_entry_t     rd_data
);
  import maml_pkg::*;

  maml_entry_t             mem [NUM_ALARMS];
  logic [NUM_ALARMS-1:0]   vld_r;
  maml_entry_t             mem_q_r;
  logic                    vld_q_r;
  logic [IDX_W-1:0]        wr_idx;

  assign wr_idx = wr.addr[IDX_W-1:0];

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // Valid bits stand in for the all-zero reset of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

`default_nettype wire

// ===== design/multi_alarm_match_latch_unit.sv =====
// Top level of the multi-alarm match and latch unit.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------------------
//  in_     | in_valid / in_stall   | func hour minute clock_mode alarm_index enable melody
//  out_    | out_valid / out_stall | fired fired_index fired_melody ringing ringing_index
//
// A time tick walks the alarm table one entry a cycle through the read port of the
// table memory in ST_SCAN, then passes through ST_DONE before the input slot is free.
// Silence and configure items go from ST_IDLE straight to ST_DONE. One item is in flight at a time.
// rst_n (synchronous) clears the table valid bits, latches, ringing state and handshakes.
// The finished result sits in an output register; while out_stall holds it there, the
// block still takes the next item, and only the result after that waits in ST_DONE.
`timescale 1ns / 1ps
`default_nettype none

module multi_alarm_match_latch_unit #(
  parameter int NUM_ALARMS = maml_pkg::NUM_ALARMS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [maml_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [maml_pkg::HOUR_W-1:0]  in_hour,
  input  wire logic [maml_pkg::MIN_W-1:0]   in_minute,
  input  wire logic                         in_clock_mode,
  input  wire logic [maml_pkg::AIDX_W-1:0]  in_alarm_index,
  input  wire logic                         in_enable,
  input  wire logic [maml_pkg::MEL_W-1:0]   in_melody,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_fired,
  output logic [maml_pkg::AIDX_W-1:0]       out_fired_index,
  output logic [maml_pkg::MEL_W-1:0]        out_fired_melody,
  output logic                              out_ringing,
  output logic [maml_pkg::AIDX_W-1:0]       out_ringing_index
);
  import maml_pkg::*;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);

  // Sequencer and scan state
  maml_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [HOUR_W-1:0]       hour_r, hour_nxt;
  logic [MIN_W-1:0]        minute_r, minute_nxt;
  logic                    can_fire_r, can_fire_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        f_idx_r, f_idx_nxt;
  logic [MEL_W-1:0]        f_mel_r, f_mel_nxt;
  logic [NUM_ALARMS-1:0]   mask_r, mask_nxt;

  // Architectural state besides the table
  logic [NUM_ALARMS-1:0]   latch_r, latch_nxt;
  logic                    ringing_r, ringing_nxt;
  logic [IDX_W-1:0]        ring_idx_r, ring_idx_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_fired_r, out_fired_nxt;
  logic [AIDX_W-1:0]       out_fidx_r, out_fidx_nxt;
  logic [MEL_W-1:0]        out_fmel_r, out_fmel_nxt;
  logic                    out_ring_r, out_ring_nxt;
  logic [AIDX_W-1:0]       out_ridx_r, out_ridx_nxt;

  // Table access
  maml_wr_t                tbl_wr;
  logic [IDX_W-1:0]        tbl_rd_addr;
  maml_entry_t             ent;

  logic                    in_xfer;
  logic                    cfg_in_bank;
  logic                    hm_eq;
  logic                    hit;
  logic                    found_now;
  logic [NUM_ALARMS-1:0]   mask_now;
  logic [NUM_ALARMS-1:0]   latch_clr;

  maml_table #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_addr (tbl_rd_addr),
    .rd_data (ent)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign cfg_in_bank = ({1'b0, in_alarm_index} < (AIDX_W + 1)'(NUM_ALARMS));

  // Configure writes go straight into the table at the transfer edge; no tick is in
  // flight then, so the scan never races a write.
  always_comb begin
    tbl_wr.en          = in_xfer && (in_func == FUNC_CONFIG) && cfg_in_bank;
    tbl_wr.addr        = in_alarm_index;
    tbl_wr.data.hour   = in_hour;
    tbl_wr.data.minute = in_minute;
    tbl_wr.data.enable = in_enable;
    tbl_wr.data.melody = in_melody;
  end

  // Entry 0 is read in the transfer cycle, entry k+1 while entry k is examined.
  assign tbl_rd_addr = (state_r == ST_SCAN && cnt_r != LAST_IDX) ? cnt_r + 1'b1 : '0;

  // Per-entry checks on the entry now on the read port
  assign hm_eq     = (ent.hour == hour_r) && (ent.minute == minute_r);
  assign hit       = can_fire_r && !found_r && ent.enable && hm_eq && !latch_r[cnt_r];
  assign found_now = found_r || hit;

  always_comb begin
    latch_clr = latch_r;
    if (ent.minute != minute_r) begin
      latch_clr[cnt_r] = 1'b0;
    end
    for (int i = 0; i < NUM_ALARMS; i++) begin
      mask_now[i] = mask_r[i] || (hm_eq && (cnt_r == IDX_W'(i)));
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    can_fire_nxt  = can_fire_r;
    found_nxt     = found_r;
    f_idx_nxt     = f_idx_r;
    f_mel_nxt     = f_mel_r;
    mask_nxt      = mask_r;
    latch_nxt     = latch_r;
    ringing_nxt   = ringing_r;
    ring_idx_nxt  = ring_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fired_nxt = out_fired_r;
    out_fidx_nxt  = out_fidx_r;
    out_fmel_nxt  = out_fmel_r;
    out_ring_nxt  = out_ring_r;
    out_ridx_nxt  = out_ridx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          found_nxt = 1'b0;
          f_idx_nxt = '0;
          f_mel_nxt = '0;
          state_nxt = ST_DONE;
          unique case (in_func)
            FUNC_TICK: begin
              hour_nxt     = in_hour;
              minute_nxt   = in_minute;
              can_fire_nxt = in_clock_mode && !ringing_r;
              mask_nxt     = '0;
              cnt_nxt      = '0;
              state_nxt    = ST_SCAN;
            end
            FUNC_SILENCE: begin
              // ringing implies an index has been recorded
              if (ringing_r) begin
                ringing_nxt          = 1'b0;
                latch_nxt[ring_idx_r] = 1'b1;
              end
            end
            FUNC_CONFIG: begin
              if (cfg_in_bank) begin
                latch_nxt[in_alarm_index[IDX_W-1:0]] = 1'b0;
              end
            end
            default: begin
              // unused code: no state change
            end
          endcase
        end
      end

      ST_SCAN: begin
        latch_nxt = latch_clr;
        mask_nxt  = mask_now;
        found_nxt = found_now;
        if (hit) begin
          f_idx_nxt = cnt_r;
          f_mel_nxt = ent.melody;
        end
        if (cnt_r == LAST_IDX) begin
          if (found_now) begin
            latch_nxt    = latch_clr | mask_now;
            ringing_nxt  = 1'b1;
            ring_idx_nxt = hit ? cnt_r : f_idx_r;
          end
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = found_r;
          out_fidx_nxt  = AIDX_W'(f_idx_r);
          out_fmel_nxt  = f_mel_r;
          out_ring_nxt  = ringing_r;
          out_ridx_nxt  = AIDX_W'(ring_idx_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latch_r     <= '0;
      ringing_r   <= 1'b0;
      ring_idx_r  <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latch_r     <= latch_nxt;
      ringing_r   <= ringing_nxt;
      ring_idx_r  <= ring_idx_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    hour_r     <= hour_nxt;
    minute_r   <= minute_nxt;
    can_fire_r <= can_fire_nxt;
    f_idx_r    <= f_idx_nxt;
    f_mel_r    <= f_mel_nxt;
    mask_r     <= mask_nxt;
    out_fired_r <= out_fired_nxt;
    out_fidx_r  <= out_fidx_nxt;
    out_fmel_r  <= out_fmel_nxt;
    out_ring_r  <= out_ring_nxt;
    out_ridx_r  <= out_ridx_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_fired_index   = out_fidx_r;
  assign out_fired_melody  = out_fmel_r;
  assign out_ringing       = out_ring_r;
  assign out_ringing_index = out_ridx_r;

  // A fired result always leaves that entry ringing
  a_fired_rings: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_ringing && (out_ringing_index == out_fired_index))
    else $error("fired result without matching ringing state");

  // Ringing starts only at the end of a tick scan
  a_ring_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ringing_r) |-> $past(state_r) == ST_SCAN)
    else $error("ringing started outside a scan");

  // The entry that starts ringing has its latch set
  a_ring_latched: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ringing_r) |-> latch_r[ring_idx_r])
    else $error("ringing entry not latched");

  // Scan counter stays within the bank
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= LAST_IDX)
    else $error("scan index beyond bank");

endmodule

`default_nettype wire

// ===== dv/multi_alarm_match_latch_checker.sv =====
// Checker for the multi-alarm unit: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module multi_alarm_match_latch_checker #(
  parameter int NUM_ALARMS = maml_pkg::NUM_ALARMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [maml_pkg::FUNC_W-1:0] in_func,
  input  logic [maml_pkg::HOUR_W-1:0] in_hour,
  input  logic [maml_pkg::MIN_W-1:0]  in_minute,
  input  logic                        in_clock_mode,
  input  logic [maml_pkg::AIDX_W-1:0] in_alarm_index,
  input  logic                        in_enable,
  input  logic [maml_pkg::MEL_W-1:0]  in_melody,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_fired,
  input  logic [maml_pkg::AIDX_W-1:0] out_fired_index,
  input  logic [maml_pkg::MEL_W-1:0]  out_fired_melody,
  input  logic                        out_ringing,
  input  logic [maml_pkg::AIDX_W-1:0] out_ringing_index,
  output int                          mismatches,
  output int                          awaiting
);
  import maml_pkg::*;

  typedef struct packed {
    logic              fired;
    logic [AIDX_W-1:0] fired_index;
    logic [MEL_W-1:0]  fired_melody;
    logic              ringing;
    logic [AIDX_W-1:0] ringing_index;
  } alarm_outcome_t;

  // predicted copy of the bank and ringing state
  maml_entry_t           alarm_bank [MAX_ALARMS];
  logic [MAX_ALARMS-1:0] fired_mask;
  logic                  ring_on;
  logic [AIDX_W-1:0]     ring_idx;
  logic                  ring_idx_ok;
  alarm_outcome_t        outcome_q [$];

  function automatic alarm_outcome_t alarm_step(
    input logic [FUNC_W-1:0] func,
    input logic [HOUR_W-1:0] hour,
    input logic [MIN_W-1:0]  minute,
    input logic              mode,
    input logic [AIDX_W-1:0] idx,
    input logic              en,
    input logic [MEL_W-1:0]  mel
  );
    alarm_outcome_t res;
    int hit;
    res = '0;
    hit = -1;
    case (func)
      FUNC_TICK: begin
        for (int i = 0; i < NUM_ALARMS; i++)
          if (alarm_bank[i].minute != minute) fired_mask[i] = 1'b0;
        if (mode && !ring_on) begin
          for (int i = 0; i < NUM_ALARMS && hit < 0; i++)
            if (alarm_bank[i].enable && alarm_bank[i].hour == hour &&
                alarm_bank[i].minute == minute && !fired_mask[i]) hit = i;
          if (hit >= 0) begin
            res.fired        = 1'b1;
            res.fired_index  = AIDX_W'(hit);
            res.fired_melody = alarm_bank[hit].melody;
            ring_on          = 1'b1;
            ring_idx         = AIDX_W'(hit);
            ring_idx_ok      = 1'b1;
            // latch every entry at this time, enabled or not
            for (int i = 0; i < NUM_ALARMS; i++)
              if (alarm_bank[i].hour == hour && alarm_bank[i].minute == minute)
                fired_mask[i] = 1'b1;
          end
        end
      end
      FUNC_SILENCE: begin
        if (ring_on) begin
          ring_on = 1'b0;
          if (ring_idx_ok && int'(ring_idx) < NUM_ALARMS) fired_mask[ring_idx] = 1'b1;
        end
      end
      FUNC_CONFIG: begin
        if (int'(idx) < NUM_ALARMS) begin
          alarm_bank[idx] = {mel, en, minute, hour};
          fired_mask[idx] = 1'b0;
        end
      end
      default: ;
    endcase
    res.ringing       = ring_on;
    res.ringing_index = ring_idx;
    return res;
  endfunction

  function automatic void field_check(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    alarm_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ALARMS; i++) alarm_bank[i] = '0;
      fired_mask  = '0;
      ring_on     = 1'b0;
      ring_idx    = '0;
      ring_idx_ok = 1'b0;
      outcome_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          field_check("fired", int'(want.fired), int'(out_fired));
          field_check("fired_index", int'(want.fired_index), int'(out_fired_index));
          field_check("fired_melody", int'(want.fired_melody), int'(out_fired_melody));
          field_check("ringing", int'(want.ringing), int'(out_ringing));
          field_check("ringing_index", int'(want.ringing_index), int'(out_ringing_index));
        end
      end
      if (in_valid && !in_stall)
        outcome_q.push_back(alarm_step(in_func, in_hour, in_minute, in_clock_mode,
                                       in_alarm_index, in_enable, in_melody));
    end
    awaiting = outcome_q.size();
  end

endmodule

// ===== dv/multi_alarm_match_latch_unit_tb.sv =====
// Testbench top for the multi-alarm unit: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module multi_alarm_match_latch_unit_tb;
  import maml_pkg::*;

  localparam int BANK        = NUM_ALARMS_DEF;
  localparam int ITEM_COUNT  = 1550;
  // receiver goes quiet for a long stretch once this many results have arrived
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  // function code the block does not define; must leave all state alone
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              clock_mode;
    logic [AIDX_W-1:0] alarm_index;
    logic              enable;
    logic [MEL_W-1:0]  melody;
  } alarm_req_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [HOUR_W-1:0] in_hour;
  logic [MIN_W-1:0]  in_minute;
  logic              in_clock_mode;
  logic [AIDX_W-1:0] in_alarm_index;
  logic              in_enable;
  logic [MEL_W-1:0]  in_melody;
  logic              out_valid;
  logic              out_stall;
  logic              out_fired;
  logic [AIDX_W-1:0] out_fired_index;
  logic [MEL_W-1:0]  out_fired_melody;
  logic              out_ringing;
  logic [AIDX_W-1:0] out_ringing_index;
  int                mismatches;
  int                awaiting;

  // steady phases: the side in question stops idling for a run of transfers
  bit                sender_steady;
  bit                receiver_steady;
  // a few "hot" alarm times, so configures and ticks actually meet
  logic [HOUR_W-1:0] hot_hour [4];
  logic [MIN_W-1:0]  hot_min  [4];

  always #6 clk = ~clk;

  multi_alarm_match_latch_unit #(.NUM_ALARMS(BANK)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_clock_mode    (in_clock_mode),
    .in_alarm_index   (in_alarm_index),
    .in_enable        (in_enable),
    .in_melody        (in_melody),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_fired_index  (out_fired_index),
    .out_fired_melody (out_fired_melody),
    .out_ringing      (out_ringing),
    .out_ringing_index(out_ringing_index)
  );

  multi_alarm_match_latch_checker #(.NUM_ALARMS(BANK)) alarm_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_clock_mode    (in_clock_mode),
    .in_alarm_index   (in_alarm_index),
    .in_enable        (in_enable),
    .in_melody        (in_melody),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_fired_index  (out_fired_index),
    .out_fired_melody (out_fired_melody),
    .out_ringing      (out_ringing),
    .out_ringing_index(out_ringing_index),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  function automatic alarm_req_t mk_req(
    input logic [FUNC_W-1:0] func,
    input logic [HOUR_W-1:0] hour,
    input logic [MIN_W-1:0]  minute,
    input logic              mode,
    input logic [AIDX_W-1:0] idx,
    input logic              en,
    input logic [MEL_W-1:0]  mel
  );
    alarm_req_t r;
    r.func        = func;
    r.hour        = hour;
    r.minute      = minute;
    r.clock_mode  = mode;
    r.alarm_index = idx;
    r.enable      = en;
    r.melody      = mel;
    return r;
  endfunction

  // Mostly ticks and configures around the hot times, so alarms fire, latch,
  // get silenced and re-armed; the rest is silence, unused codes and raw noise.
  function automatic alarm_req_t random_req();
    alarm_req_t r;
    int pick;
    int slot;
    pick          = $urandom_range(0, 99);
    slot          = $urandom_range(0, 3);
    r.func        = FUNC_TICK;
    r.hour        = HOUR_W'($urandom_range(0, 31));
    r.minute      = MIN_W'($urandom_range(0, 63));
    r.clock_mode  = 1'($urandom_range(0, 1));
    r.alarm_index = AIDX_W'($urandom_range(0, 7));
    r.enable      = 1'($urandom_range(0, 1));
    r.melody      = MEL_W'($urandom_range(0, 15));
    if (pick < 60) begin
      if ($urandom_range(0, 9) < 8) begin
        r.hour   = hot_hour[slot];
        // the next minute now and then, which clears the latches
        r.minute = hot_min[slot] + MIN_W'($urandom_range(0, 3) == 0);
      end
      r.clock_mode = ($urandom_range(0, 9) != 0);
    end else if (pick < 75) begin
      r.func = FUNC_SILENCE;
    end else if (pick < 95) begin
      r.func = FUNC_CONFIG;
      if ($urandom_range(0, 4) != 0) begin
        r.hour   = hot_hour[slot];
        r.minute = hot_min[slot];
      end
      r.enable = ($urandom_range(0, 3) != 0);
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  // Offer one item from a falling edge and hold it until the transfer.
  // Returns at the falling edge after the transfer.
  task automatic send_req(input alarm_req_t r);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= r.func;
    in_hour        <= r.hour;
    in_minute      <= r.minute;
    in_clock_mode  <= r.clock_mode;
    in_alarm_index <= r.alarm_index;
    in_enable      <= r.enable;
    in_melody      <= r.melody;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_TICK;
    in_hour        <= '0;
    in_minute      <= '0;
    in_clock_mode  <= 1'b0;
    in_alarm_index <= '0;
    in_enable      <= 1'b0;
    in_melody      <= '0;
    sender_steady   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Midnight tick on the reset bank: every entry sits at 00:00 but disabled.
    send_req(mk_req(FUNC_TICK,    0,  0, 1'b1, 0, 1'b0,  0));
    // Unused function code with every field at its top value
    send_req(mk_req(FUNC_UNUSED, 31, 63, 1'b1, 7, 1'b1, 15));
    // Silence with nothing ringing
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));
    send_req(mk_req(FUNC_CONFIG, 23, 59, 1'b0, 0, 1'b1, 15));
    // Out-of-range hour and minute are stored as raw bits
    send_req(mk_req(FUNC_CONFIG, 31, 63, 1'b0, 7, 1'b1, 10));
    // Disabled and enabled entries sharing 23:59
    send_req(mk_req(FUNC_CONFIG, 23, 59, 1'b0, 3, 1'b0,  5));
    send_req(mk_req(FUNC_CONFIG, 23, 59, 1'b0, 5, 1'b1,  9));
    // Outside clock mode nothing fires
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b0, 0, 1'b0,  0));
    // Lowest enabled entry fires; 0, 3 and 5 all latch
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b1, 0, 1'b0,  0));
    // Already ringing: no second fire
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_UNUSED,  0,  0, 1'b0, 0, 1'b0,  0));
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));
    // Same minute again: all latched, nothing fires
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b1, 0, 1'b0,  0));
    // Minute moves on, latches clear, then the alarm comes round again
    send_req(mk_req(FUNC_TICK,   23, 58, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));
    // Rewriting an entry clears only its own latch
    send_req(mk_req(FUNC_CONFIG, 23, 59, 1'b0, 0, 1'b1,  3));
    send_req(mk_req(FUNC_TICK,   23, 59, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));
    send_req(mk_req(FUNC_TICK,   31, 63, 1'b1, 0, 1'b0,  0));
    // Configure while ringing, then a tick that must not fire it yet
    send_req(mk_req(FUNC_CONFIG, 12, 30, 1'b1, 2, 1'b1,  6));
    send_req(mk_req(FUNC_TICK,   12, 30, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));
    send_req(mk_req(FUNC_TICK,   12, 30, 1'b1, 0, 1'b0,  0));
    send_req(mk_req(FUNC_SILENCE, 0,  0, 1'b0, 0, 1'b0,  0));

    // Random part
    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n % 200 == 0)
        for (int k = 0; k < 4; k++) begin
          hot_hour[k] = HOUR_W'($urandom_range(0, 31));
          hot_min[k]  = MIN_W'($urandom_range(0, 63));
        end
      if (n % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      send_req(random_req());
    end
    in_valid <= 1'b0;

    // Drain, then allow a full tick walk for anything unexpected to show up
    while (awaiting != 0) @(negedge clk);
    repeat (2 * (BANK + 2)) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stall per transfer, steady runs, and one long hold-off
  // to let the block fill up and push back on the sender.
  initial begin : drain
    int wait_n;
    int taken;
    out_stall <= 1'b0;
    taken = 0;
    receiver_steady = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 50 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      wait_n = receiver_steady ? 0 : $urandom_range(0, 19);
      if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog: the slowest honest run of roughly 1600 transfers plus the hold-off takes
  // about 1 ms at this clock; several times that is allowed.
  initial begin : watchdog
    #6_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
